// ===== rtl/core/tlex_pkg.sv =====
package tlex_pkg;

  localparam int unsigned KindW  = 5;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);
  localparam int unsigned FifoCw = $clog2(FifoDepth + 1);

  localparam logic [KindW-1:0] K_ID     = 5'd0;
  localparam logic [KindW-1:0] K_INT    = 5'd1;
  localparam logic [KindW-1:0] K_STR    = 5'd2;
  localparam logic [KindW-1:0] K_EQ     = 5'd3;
  localparam logic [KindW-1:0] K_ARROW  = 5'd4;
  localparam logic [KindW-1:0] K_ABEGIN = 5'd5;
  localparam logic [KindW-1:0] K_AEND   = 5'd6;
  localparam logic [KindW-1:0] K_LPAREN = 5'd7;
  localparam logic [KindW-1:0] K_RPAREN = 5'd8;
  localparam logic [KindW-1:0] K_LBRACE = 5'd9;
  localparam logic [KindW-1:0] K_RBRACE = 5'd10;
  localparam logic [KindW-1:0] K_COLON  = 5'd11;
  localparam logic [KindW-1:0] K_COMMA  = 5'd12;
  localparam logic [KindW-1:0] K_LT     = 5'd13;
  localparam logic [KindW-1:0] K_GT     = 5'd14;
  localparam logic [KindW-1:0] K_SEMI   = 5'd15;
  localparam logic [KindW-1:0] K_PLUS   = 5'd16;
  localparam logic [KindW-1:0] K_MINUS  = 5'd17;
  localparam logic [KindW-1:0] K_SLASH  = 5'd18;
  localparam logic [KindW-1:0] K_STAR   = 5'd19;
  localparam logic [KindW-1:0] K_EOF    = 5'd20;
  localparam logic [KindW-1:0] K_ERR    = 5'd21;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       chr;
    logic             cvalid;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } step_t;

endpackage

// ===== rtl/core/tlex_core.sv =====
module tlex_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  output tlex_pkg::step_t   step_o
);
  import tlex_pkg::*;

  localparam logic [ModeW-1:0] M_IDLE  = 4'd0;
  localparam logic [ModeW-1:0] M_ID    = 4'd1;
  localparam logic [ModeW-1:0] M_NUM   = 4'd2;
  localparam logic [ModeW-1:0] M_STR   = 4'd3;
  localparam logic [ModeW-1:0] M_SLASH = 4'd4;
  localparam logic [ModeW-1:0] M_LINE  = 4'd5;
  localparam logic [ModeW-1:0] M_BLOCK = 4'd6;
  localparam logic [ModeW-1:0] M_BSTAR = 4'd7;
  localparam logic [ModeW-1:0] M_EQ    = 4'd8;
  localparam logic [ModeW-1:0] M_LBR   = 4'd9;
  localparam logic [ModeW-1:0] M_RBR   = 4'd10;
  localparam logic [ModeW-1:0] M_SKIP  = 4'd11;

  localparam logic [7:0] C_NUL   = 8'd0;
  localparam logic [7:0] C_LF    = 8'd10;
  localparam logic [7:0] C_CR    = 8'd13;
  localparam logic [7:0] C_TAB   = 8'd9;
  localparam logic [7:0] C_SP    = 8'd32;
  localparam logic [7:0] C_QUOTE = 8'd34;
  localparam logic [7:0] C_SLASH = 8'd47;
  localparam logic [7:0] C_STAR  = 8'd42;
  localparam logic [7:0] C_EQ    = 8'd61;
  localparam logic [7:0] C_GT    = 8'd62;
  localparam logic [7:0] C_LBR   = 8'd91;
  localparam logic [7:0] C_RBR   = 8'd93;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             hv;
    logic             load;
    logic             put;
    res_t             r;
  } start_t;

  function automatic res_t mk(logic [KindW-1:0] k, logic [7:0] c, logic v, logic l);
    res_t r;
    r.kind   = k;
    r.chr    = c;
    r.cvalid = v;
    r.last   = l;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b inside {[8'd97:8'd122]}) || (b inside {[8'd65:8'd90]});
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'd48:8'd57]};
  endfunction

  function automatic start_t start_byte(logic [7:0] b);
    start_t s;
    s = '0;
    s.mode = M_IDLE;
    if (b == C_NUL) begin
      s.put = 1'b1;
      s.r   = mk(K_EOF, 8'd0, 1'b0, 1'b1);
    end else if (b inside {C_CR, C_LF, C_SP, C_TAB}) begin
      s.put = 1'b0;
    end else if (is_letter(b)) begin
      s.mode = M_ID;
      s.load = 1'b1;
      s.hv   = 1'b1;
    end else if (is_digit(b)) begin
      s.mode = M_NUM;
      s.load = 1'b1;
      s.hv   = 1'b1;
    end else if (b == C_QUOTE) begin
      s.mode = M_STR;
    end else if (b == C_SLASH) begin
      s.mode = M_SLASH;
    end else if (b == C_EQ) begin
      s.mode = M_EQ;
    end else if (b == C_LBR) begin
      s.mode = M_LBR;
    end else if (b == C_RBR) begin
      s.mode = M_RBR;
    end else begin
      s.put = 1'b1;
      case (b)
        8'd40:   s.r = mk(K_LPAREN, b, 1'b1, 1'b1);
        8'd41:   s.r = mk(K_RPAREN, b, 1'b1, 1'b1);
        8'd123:  s.r = mk(K_LBRACE, b, 1'b1, 1'b1);
        8'd125:  s.r = mk(K_RBRACE, b, 1'b1, 1'b1);
        8'd58:   s.r = mk(K_COLON, b, 1'b1, 1'b1);
        8'd44:   s.r = mk(K_COMMA, b, 1'b1, 1'b1);
        8'd60:   s.r = mk(K_LT, b, 1'b1, 1'b1);
        8'd62:   s.r = mk(K_GT, b, 1'b1, 1'b1);
        8'd59:   s.r = mk(K_SEMI, b, 1'b1, 1'b1);
        8'd43:   s.r = mk(K_PLUS, b, 1'b1, 1'b1);
        8'd45:   s.r = mk(K_MINUS, b, 1'b1, 1'b1);
        8'd42:   s.r = mk(K_STAR, b, 1'b1, 1'b1);
        default: begin
          s.r    = mk(K_ERR, b, 1'b1, 1'b1);
          s.mode = M_SKIP;
        end
      endcase
    end
    return s;
  endfunction

  logic [ModeW-1:0] mode_q, mode_d;
  logic [7:0]       hc_q, hc_d;
  logic             hv_q, hv_d;
  start_t           sb;
  step_t            st;
  logic [7:0]       br;

  always_comb begin
    sb    = start_byte(byte_i);
    st    = '0;
    mode_d = mode_q;
    hc_d  = hc_q;
    hv_d  = hv_q;
    br    = (mode_q == M_LBR) ? C_LBR : C_RBR;
    case (mode_q)
      M_ID, M_NUM: begin
        if ((mode_q == M_ID) ? is_letter(byte_i) : is_digit(byte_i)) begin
          st.res0 = mk((mode_q == M_ID) ? K_ID : K_INT, hc_q, 1'b1, 1'b0);
          st.cnt  = 2'd1;
          hc_d    = byte_i;
          hv_d    = 1'b1;
        end else begin
          st.res0 = mk((mode_q == M_ID) ? K_ID : K_INT, hc_q, 1'b1, 1'b1);
          st.res1 = sb.r;
          st.cnt  = {1'b0, sb.put} + 2'd1;
          mode_d  = sb.mode;
          hv_d    = sb.hv;
          if (sb.load) hc_d = byte_i;
        end
      end
      M_STR: begin
        if (byte_i == C_QUOTE) begin
          st.res0 = hv_q ? mk(K_STR, hc_q, 1'b1, 1'b1) : mk(K_STR, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd1;
          mode_d  = M_IDLE;
          hv_d    = 1'b0;
        end else if (byte_i == C_NUL) begin
          st.res0 = mk(K_ERR, 8'd0, 1'b0, 1'b1);
          st.res1 = mk(K_EOF, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd2;
          mode_d  = M_IDLE;
          hv_d    = 1'b0;
        end else begin
          st.res0 = mk(K_STR, hc_q, 1'b1, 1'b0);
          st.cnt  = {1'b0, hv_q};
          hc_d    = byte_i;
          hv_d    = 1'b1;
        end
      end
      M_SLASH: begin
        if (byte_i == C_SLASH) begin
          mode_d = M_LINE;
        end else if (byte_i == C_STAR) begin
          mode_d = M_BLOCK;
        end else begin
          st.res0 = mk(K_SLASH, C_SLASH, 1'b1, 1'b1);
          st.res1 = sb.r;
          st.cnt  = {1'b0, sb.put} + 2'd1;
          mode_d  = sb.mode;
          hv_d    = sb.hv;
          if (sb.load) hc_d = byte_i;
        end
      end
      M_LINE: begin
        if (byte_i == C_NUL) begin
          st.res0 = mk(K_EOF, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd1;
          mode_d  = M_IDLE;
        end else if (byte_i == C_LF) begin
          mode_d = M_IDLE;
        end
      end
      M_BLOCK, M_BSTAR: begin
        if (byte_i == C_NUL) begin
          st.res0 = mk(K_EOF, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd1;
          mode_d  = M_IDLE;
        end else if (byte_i == C_STAR) begin
          mode_d = M_BSTAR;
        end else if (byte_i == C_SLASH && mode_q == M_BSTAR) begin
          mode_d = M_IDLE;
        end else begin
          mode_d = M_BLOCK;
        end
      end
      M_EQ: begin
        if (byte_i == C_GT) begin
          st.res0 = mk(K_ARROW, C_EQ, 1'b1, 1'b1);
          st.cnt  = 2'd1;
          mode_d  = M_IDLE;
        end else begin
          st.res0 = mk(K_EQ, C_EQ, 1'b1, 1'b1);
          st.res1 = sb.r;
          st.cnt  = {1'b0, sb.put} + 2'd1;
          mode_d  = sb.mode;
          hv_d    = sb.hv;
          if (sb.load) hc_d = byte_i;
        end
      end
      M_LBR, M_RBR: begin
        st.cnt = 2'd1;
        if (byte_i == br) begin
          st.res0 = mk((mode_q == M_LBR) ? K_ABEGIN : K_AEND, br, 1'b1, 1'b1);
          mode_d  = M_IDLE;
        end else if (byte_i == C_NUL) begin
          st.res0 = mk(K_ERR, br, 1'b1, 1'b1);
          st.res1 = mk(K_EOF, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd2;
          mode_d  = M_IDLE;
        end else begin
          st.res0 = mk(K_ERR, br, 1'b1, 1'b1);
          mode_d  = M_SKIP;
        end
      end
      M_SKIP: begin
        if (byte_i == C_NUL) begin
          st.res0 = mk(K_EOF, 8'd0, 1'b0, 1'b1);
          st.cnt  = 2'd1;
          mode_d  = M_IDLE;
        end
      end
      default: begin
        st.res0 = sb.r;
        st.cnt  = {1'b0, sb.put};
        mode_d  = sb.mode;
        hv_d    = sb.hv;
        if (sb.load) hc_d = byte_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hc_q   <= 8'd0;
      hv_q   <= 1'b0;
    end else if (en_i) begin
      mode_q <= mode_d;
      hc_q   <= hc_d;
      hv_q   <= hv_d;
    end
  end

  assign step_o = st;

endmodule

// ===== rtl/core/tlex_fifo.sv =====
module tlex_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlex_pkg::step_t            push_i,
  input  logic                       pop_i,
  output tlex_pkg::res_t             head_o,
  output logic [tlex_pkg::FifoCw-1:0] count_o
);
  import tlex_pkg::*;

  res_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FifoCw-1:0] count_q, count_d;

  always_comb begin
    wp_d    = wp_q + FifoAw'(push_i.cnt);
    rp_d    = rp_q + FifoAw'(pop_i);
    count_d = count_q + FifoCw'(push_i.cnt) - FifoCw'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wp_q + FifoAw'(1)] <= push_i.res1;
  end

  assign head_o  = mem_q[rp_q];
  assign count_o = count_q;

endmodule

// ===== rtl/core/token_lexer_top.sv =====
// Streaming lexer: source bytes in, token characters out.
// Slave channel s_axis_*: one source byte per item, a zero byte ends the
// input and yields an eof token; the lexer is then ready for a new input.
// Master channel m_axis_*: one result per item. Identifiers, numbers and
// string bodies arrive one character per item with tlast on the final one;
// operators, eof and error tokens are single items with tlast set.
// Each accepted byte updates the lexer state in the same cycle and writes
// zero, one or two results into a four-entry result queue; the first one is
// visible on the master side in the next cycle. A run character is shown
// only once the following byte is taken, since that byte decides tlast.
// Throughput: one byte per cycle while the queue holds at most two results;
// bytes that yield two results (a finished token followed by an operator,
// eof or error, or an error followed by eof) fill two queue entries each.
// Reset clears the lexer to idle between tokens and empties the queue.
// When the receiver stalls the queue fills and s_axis_tready_o drops once
// three results wait; no result is lost or repeated.
module token_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] token_char
  output logic [5:0]  m_axis_tuser_o,   // [4:0] token_kind, [5] char_valid
  output logic        m_axis_tlast_o    // token_last
);
  import tlex_pkg::*;

  logic                accept;
  logic                pop;
  step_t               step;
  step_t               push;
  res_t                head;
  logic [FifoCw-1:0]   count;

  assign s_axis_tready_o = count < FifoCw'(FifoDepth - 1);
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = count != '0;
  assign pop = m_axis_tvalid_o & m_axis_tready_i;

  tlex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .byte_i (s_axis_tdata_i),
    .step_o (step)
  );

  always_comb begin
    push = step;
    if (!accept) push.cnt = 2'd0;
  end

  tlex_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign m_axis_tdata_o = head.chr;
  assign m_axis_tuser_o = {head.cvalid, head.kind};
  assign m_axis_tlast_o = head.last;

`ifndef ASSERT_OFF
  a_eof_on_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tdata_i == 8'd0 |-> step.cnt != 2'd0)
    else $error("zero byte produced no result");

  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && step.cnt != 2'd0 |=> m_axis_tvalid_o)
    else $error("result not presented after accepted byte");

  a_eof_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && head.kind == K_EOF |-> head.last && !head.cvalid)
    else $error("eof result malformed");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= FifoCw'(FifoDepth))
    else $error("result queue overflow");
`endif

endmodule

// ===== sim/tb_token_lexer_top.sv =====
`timescale 1ns / 100ps

module tb_token_lexer_top;
  import tlex_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_LBR   = "[";
  localparam logic [7:0] CH_RBR   = "]";

  localparam int StallLimit   = 1000;
  localparam int TailCycles   = 20;
  localparam int RandomItems  = 165;

  typedef enum logic [3:0] {
    LX_IDLE,
    LX_IDENT,
    LX_NUMBER,
    LX_STRING,
    LX_SLASH,
    LX_LINE_CMT,
    LX_BLOCK_CMT,
    LX_BLOCK_STAR,
    LX_EQUAL,
    LX_LBRACKET,
    LX_RBRACKET,
    LX_DISCARD
  } lex_mode_e;

  class lexer_scoreboard;
    lex_mode_e  lex_state;
    logic [7:0] pend_char;
    logic       pend_valid;
    res_t       expected_tokens[$];
    int         errors;

    function new();
      lex_state  = LX_IDLE;
      pend_char  = 8'd0;
      pend_valid = 1'b0;
      errors     = 0;
    endfunction

    function void add_token(logic [KindW-1:0] kind, logic [7:0] chr, logic cvalid,
                            logic last);
      res_t tok;
      tok.kind   = kind;
      tok.chr    = chr;
      tok.cvalid = cvalid;
      tok.last   = last;
      expected_tokens.push_back(tok);
    endfunction

    function bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function logic [KindW-1:0] punct_kind(logic [7:0] b);
      case (b)
        "(":     return K_LPAREN;
        ")":     return K_RPAREN;
        "{":     return K_LBRACE;
        "}":     return K_RBRACE;
        ":":     return K_COLON;
        ",":     return K_COMMA;
        "<":     return K_LT;
        ">":     return K_GT;
        ";":     return K_SEMI;
        "+":     return K_PLUS;
        "-":     return K_MINUS;
        "*":     return K_STAR;
        default: return K_ERR;
      endcase
    endfunction

    function void begin_token(logic [7:0] b);
      logic [KindW-1:0] k;
      lex_state  = LX_IDLE;
      pend_valid = 1'b0;
      if (b == CH_NUL) begin
        add_token(K_EOF, 8'd0, 1'b0, 1'b1);
      end else if (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB) begin
        lex_state = LX_IDLE;
      end else if (is_letter(b) || is_digit(b)) begin
        lex_state  = is_letter(b) ? LX_IDENT : LX_NUMBER;
        pend_char  = b;
        pend_valid = 1'b1;
      end else if (b == CH_QUOTE) begin
        lex_state = LX_STRING;
      end else if (b == CH_SLASH) begin
        lex_state = LX_SLASH;
      end else if (b == CH_EQ) begin
        lex_state = LX_EQUAL;
      end else if (b == CH_LBR) begin
        lex_state = LX_LBRACKET;
      end else if (b == CH_RBR) begin
        lex_state = LX_RBRACKET;
      end else begin
        k = punct_kind(b);
        add_token(k, b, 1'b1, 1'b1);
        if (k == K_ERR) lex_state = LX_DISCARD;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [KindW-1:0] run_kind;
      logic [7:0]       br;
      bit               stays;
      case (lex_state)
        LX_IDENT, LX_NUMBER: begin
          run_kind = (lex_state == LX_IDENT) ? K_ID : K_INT;
          stays = (lex_state == LX_IDENT) ? is_letter(b) : is_digit(b);
          if (stays) begin
            add_token(run_kind, pend_char, 1'b1, 1'b0);
            pend_char  = b;
            pend_valid = 1'b1;
          end else begin
            add_token(run_kind, pend_char, 1'b1, 1'b1);
            begin_token(b);
          end
        end
        LX_STRING: begin
          if (b == CH_QUOTE) begin
            if (pend_valid) add_token(K_STR, pend_char, 1'b1, 1'b1);
            else add_token(K_STR, 8'd0, 1'b0, 1'b1);
            lex_state  = LX_IDLE;
            pend_valid = 1'b0;
          end else if (b == CH_NUL) begin
            add_token(K_ERR, 8'd0, 1'b0, 1'b1);
            add_token(K_EOF, 8'd0, 1'b0, 1'b1);
            lex_state  = LX_IDLE;
            pend_valid = 1'b0;
          end else begin
            if (pend_valid) add_token(K_STR, pend_char, 1'b1, 1'b0);
            pend_char  = b;
            pend_valid = 1'b1;
          end
        end
        LX_SLASH: begin
          if (b == CH_SLASH) begin
            lex_state = LX_LINE_CMT;
          end else if (b == CH_STAR) begin
            lex_state = LX_BLOCK_CMT;
          end else begin
            add_token(K_SLASH, CH_SLASH, 1'b1, 1'b1);
            begin_token(b);
          end
        end
        LX_LINE_CMT: begin
          if (b == CH_NUL) begin
            add_token(K_EOF, 8'd0, 1'b0, 1'b1);
            lex_state = LX_IDLE;
          end else if (b == CH_LF) begin
            lex_state = LX_IDLE;
          end
        end
        LX_BLOCK_CMT, LX_BLOCK_STAR: begin
          if (b == CH_NUL) begin
            add_token(K_EOF, 8'd0, 1'b0, 1'b1);
            lex_state = LX_IDLE;
          end else if (b == CH_STAR) begin
            lex_state = LX_BLOCK_STAR;
          end else if (b == CH_SLASH && lex_state == LX_BLOCK_STAR) begin
            lex_state = LX_IDLE;
          end else begin
            lex_state = LX_BLOCK_CMT;
          end
        end
        LX_EQUAL: begin
          if (b == CH_GT) begin
            add_token(K_ARROW, CH_EQ, 1'b1, 1'b1);
            lex_state = LX_IDLE;
          end else begin
            add_token(K_EQ, CH_EQ, 1'b1, 1'b1);
            begin_token(b);
          end
        end
        LX_LBRACKET, LX_RBRACKET: begin
          br = (lex_state == LX_LBRACKET) ? CH_LBR : CH_RBR;
          if (b == br) begin
            add_token((br == CH_LBR) ? K_ABEGIN : K_AEND, br, 1'b1, 1'b1);
            lex_state = LX_IDLE;
          end else begin
            add_token(K_ERR, br, 1'b1, 1'b1);
            lex_state = LX_DISCARD;
            if (b == CH_NUL) begin
              add_token(K_EOF, 8'd0, 1'b0, 1'b1);
              lex_state = LX_IDLE;
            end
          end
        end
        LX_DISCARD: begin
          if (b == CH_NUL) begin
            add_token(K_EOF, 8'd0, 1'b0, 1'b1);
            lex_state = LX_IDLE;
          end
        end
        default: begin_token(b);
      endcase
    endfunction

    function void check_token(res_t got);
      res_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token kind %0d char %h cvalid %b last %b", $time,
                 got.kind, got.chr, got.cvalid, got.last);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.chr !== want.chr || got.cvalid !== want.cvalid ||
          got.last !== want.last) begin
        $write("%0t: token mismatch: expected kind %0d char %h cvalid %b last %b,",
               $time, want.kind, want.chr, want.cvalid, want.last);
        $display(" actual kind %0d char %h cvalid %b last %b",
                 got.kind, got.chr, got.cvalid, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'd0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [5:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  lexer_scoreboard sb;
  int          src_idle_pct  = 18;
  int          sink_idle_pct = 50;
  int          items_sent    = 0;
  int          stall_cycles  = 0;
  logic [7:0]  src_q[$];

  token_lexer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind   = m_axis_tuser_o[4:0];
        got.chr    = m_axis_tdata_o;
        got.cvalid = m_axis_tuser_o[5];
        got.last   = m_axis_tlast_o;
        sb.check_token(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, StallLimit);
      $display("tb_token_lexer_top NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_source();
    foreach (src_q[i]) send_byte(src_q[i]);
  endtask

  task automatic drain_tokens();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_tokens.size() != 0);
  endtask

  function automatic void gen_source();
    string      ops;
    string      pairs[4];
    logic [7:0] ws[4];
    logic [7:0] c;
    int         n_tok;
    int         pick;
    int         len;
    ops   = "(){}:,<>;+-*/";
    pairs = '{"=", "=>", "[[", "]]"};
    ws    = '{CH_CR, CH_LF, CH_SP, CH_TAB};
    src_q.delete();
    n_tok = $urandom_range(3, 10);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 29);
      len  = $urandom_range(0, 5);
      case (pick)
        0, 1, 2, 3, 4: begin
          for (int i = 0; i <= len; i++) begin
            c = 8'($urandom_range(0, 51));
            src_q.push_back((c < 26) ? 8'("a" + c) : 8'("A" + c - 26));
          end
        end
        5, 6, 7: begin
          for (int i = 0; i <= len % 4; i++) src_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
        8, 9, 10: begin
          src_q.push_back(CH_QUOTE);
          for (int i = 0; i < len % 5; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
            src_q.push_back(c);
          end
          src_q.push_back(CH_QUOTE);
        end
        11, 12, 13, 14: src_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
        15, 16, 17: begin
          pick = $urandom_range(0, 3);
          for (int i = 0; i < pairs[pick].len(); i++) src_q.push_back(pairs[pick][i]);
        end
        18, 19, 20, 21, 22: src_q.push_back(ws[$urandom_range(0, 3)]);
        23, 24: begin
          src_q.push_back(CH_SLASH);
          src_q.push_back(CH_SLASH);
          for (int i = 0; i < len; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
            src_q.push_back(c);
          end
          src_q.push_back(CH_LF);
        end
        25, 26: begin
          src_q.push_back(CH_SLASH);
          src_q.push_back(CH_STAR);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1)) c = $urandom_range(0, 1) ? CH_STAR : CH_SLASH;
            else c = 8'($urandom_range(1, 255));
            src_q.push_back(c);
          end
          src_q.push_back(CH_STAR);
          src_q.push_back(CH_SLASH);
        end
        27: src_q.push_back(8'($urandom_range(1, 255)));
        28: begin
          c = $urandom_range(0, 1) ? CH_LBR : CH_RBR;
          src_q.push_back(c);
          src_q.push_back(($urandom_range(0, 1)) ? 8'($urandom_range(1, 255)) : CH_SP);
        end
        default: src_q.push_back(CH_SP);
      endcase
    end
    case ($urandom_range(0, 9))
      0: begin
        src_q.push_back(CH_QUOTE);
        src_q.push_back(8'($urandom_range(1, 255)) | 8'h01);
      end
      1: begin
        src_q.push_back(CH_SLASH);
        src_q.push_back(CH_STAR);
      end
      2: begin
        src_q.push_back(CH_SLASH);
        src_q.push_back(CH_SLASH);
      end
      default: ;
    endcase
    src_q.push_back(CH_NUL);
  endfunction

  initial begin
    int base;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identifiers, numbers, strings, arrow, comment opener, brackets, bad byte
    send_text("Az09\"x\"=>/*/*/[[]]=");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    // empty string, then an unterminated one
    send_text("\"\"\"a");
    send_byte(CH_NUL);
    // line comment, then an unterminated block comment
    send_text("//\n/*");
    send_byte(CH_NUL);
    // lone brackets
    send_text("]ab");
    send_byte(CH_NUL);
    send_text("[");
    send_byte(CH_NUL);
    drain_tokens();

    base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 18;
          sink_idle_pct = 50;
        end
        1: begin
          src_idle_pct  = 50;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      while (items_sent - base < (phase + 1) * RandomItems / 3) begin
        gen_source();
        send_source();
      end
      drain_tokens();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.expected_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived, next kind %0d char %h",
               $time, sb.expected_tokens.size(), sb.expected_tokens[0].kind,
               sb.expected_tokens[0].chr);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_token_lexer_top OK");
    end else begin
      $display("tb_token_lexer_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== token_lexer_top.f =====
rtl/core/tlex_pkg.sv
rtl/core/tlex_core.sv
rtl/core/tlex_fifo.sv
rtl/core/token_lexer_top.sv
sim/tb_token_lexer_top.sv
